// ===== rtl/look_at_view_matrix_defines.svh =====
// ----------------------------------------------------------------------------
// look_at_view_matrix_defines.svh
// Assertion macros shared by the view-matrix checker.
// ----------------------------------------------------------------------------
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH

// Flag a condition that must never be seen out of reset
`define LAV_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("view matrix check failed: condition seen");

// Same-cycle implication
`define LAV_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("view matrix check failed: implication");

// Implication after a fixed number of cycles
`define LAV_AFTER(lbl, ante, cons, n) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("view matrix check failed: delayed implication");

`endif

// ===== rtl/lav_pkg.sv =====
// ----------------------------------------------------------------------------
// lav_pkg
// Constants and helpers shared by the view-matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

	// The largest scaled component magnitude of a nonzero vector sits in [2^(NORM_TOP-1), 2^NORM_TOP)
	localparam int NORM_TOP = 30;
	// Width of the sum of three squares, and of its integer root
	localparam int SQ_W = 2 * NORM_TOP + 2;
	localparam int RT_W = NORM_TOP + 1;

	// Pipeline stages through one normalize unit
	function automatic int norm_latency(input int frac);
		return 8 + RT_W + frac;
	endfunction

endpackage

// ===== rtl/lav_norm.sv =====
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined vector normalize: scale to a fixed magnitude band, square-sum,
// integer root one bit per stage, then a restoring divide one quotient bit
// per stage for each component. A side word travels along with each beat.
// ----------------------------------------------------------------------------
module lav_norm import lav_pkg::*; #(
	parameter int IN_W = 33,
	parameter int FRAC_BITS = 16,
	parameter int SB_W = 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	input  logic [2:0][IN_W-1:0]       in_vec,
	input  logic [SB_W-1:0]            in_side,
	output logic                       out_vld,
	output logic [2:0][FRAC_BITS+1:0]  out_vec,
	output logic [SB_W-1:0]            out_side
);

	localparam int PW   = $clog2(IN_W);
	localparam int QB   = FRAC_BITS + 1;
	localparam int OW   = FRAC_BITS + 2;
	localparam int NUMW = NORM_TOP + FRAC_BITS + 1;
	localparam int DVW  = (NUMW > RT_W + QB - 1) ? NUMW : RT_W + QB - 1;
	localparam int EXW  = IN_W + NORM_TOP - 1;
	localparam int SQRW = 2 * NORM_TOP;
	localparam int LAT  = norm_latency(FRAC_BITS);

	// valid and side word delay line
	logic            vld_s  [1:LAT];
	logic [SB_W-1:0] side_s [1:LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAT; i++) vld_s[i] <= 1'b0;
		end else begin
			vld_s[1] <= in_vld;
			for (int i = 2; i <= LAT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		side_s[1] <= in_side;
		for (int i = 2; i <= LAT; i++) side_s[i] <= side_s[i-1];
	end

	assign out_vld  = vld_s[LAT];
	assign out_side = side_s[LAT];

	// stage 1: split sign and magnitude
	logic [2:0][IN_W-1:0] mag_s1;
	logic [2:0]           neg_s1;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			neg_s1[c] <= in_vec[c][IN_W-1];
			mag_s1[c] <= in_vec[c][IN_W-1] ? (~in_vec[c] + 1'b1) : in_vec[c];
		end
	end

	// stage 2: find the leading one over all three magnitudes
	logic [IN_W-1:0]      mag_or;
	logic [PW-1:0]        lead_c;
	logic [PW-1:0]        lead_s2;
	logic                 zero_s2;
	logic [2:0][IN_W-1:0] mag_s2;
	logic [2:0]           neg_s2;

	always_comb begin
		mag_or = mag_s1[0] | mag_s1[1] | mag_s1[2];
		lead_c = '0;
		for (int i = 0; i < IN_W; i++) begin
			if (mag_or[i]) lead_c = PW'(i);
		end
	end

	always_ff @(posedge clk) begin
		lead_s2 <= lead_c;
		zero_s2 <= ~|mag_or;
		mag_s2  <= mag_s1;
		neg_s2  <= neg_s1;
	end

	// stage 3: scale so the largest magnitude lands in the band
	logic [EXW-1:0]           shr_c [3];
	logic [2:0][NORM_TOP-1:0] scl_s3;
	logic                     zero_s3;
	logic [2:0]               neg_s3;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			shr_c[c] = {mag_s2[c], {(NORM_TOP-1){1'b0}}} >> lead_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) scl_s3[c] <= shr_c[c][NORM_TOP-1:0];
		zero_s3 <= zero_s2;
		neg_s3  <= neg_s2;
	end

	// stage 4: squares
	logic [2:0][SQRW-1:0]     sqr_s4;
	logic [2:0][NORM_TOP-1:0] scl_s4;
	logic                     zero_s4;
	logic [2:0]               neg_s4;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			sqr_s4[c] <= SQRW'(scl_s3[c]) * SQRW'(scl_s3[c]);
		end
		scl_s4  <= scl_s3;
		zero_s4 <= zero_s3;
		neg_s4  <= neg_s3;
	end

	// stage 5 feeds the root chain: sum of squares
	logic [SQ_W-1:0]          rt_x_s    [0:RT_W];
	logic [SQ_W-1:0]          rt_r_s    [0:RT_W];
	logic [2:0][NORM_TOP-1:0] rt_scl_s  [0:RT_W];
	logic                     rt_zero_s [0:RT_W];
	logic [2:0]               rt_neg_s  [0:RT_W];

	always_ff @(posedge clk) begin
		rt_x_s[0]    <= SQ_W'(sqr_s4[0]) + SQ_W'(sqr_s4[1]) + SQ_W'(sqr_s4[2]);
		rt_r_s[0]    <= '0;
		rt_scl_s[0]  <= scl_s4;
		rt_zero_s[0] <= zero_s4;
		rt_neg_s[0]  <= neg_s4;
	end

	// integer square root, one result bit per stage
	for (genvar k = 0; k < RT_W; k++) begin : g_root
		localparam logic [SQ_W-1:0] RBIT = SQ_W'(1) << (2 * (RT_W - 1 - k));
		logic [SQ_W:0] trial;

		assign trial = {1'b0, rt_r_s[k]} + {1'b0, RBIT};

		always_ff @(posedge clk) begin
			if ({1'b0, rt_x_s[k]} >= trial) begin
				rt_x_s[k+1] <= rt_x_s[k] - trial[SQ_W-1:0];
				rt_r_s[k+1] <= (rt_r_s[k] >> 1) + RBIT;
			end else begin
				rt_x_s[k+1] <= rt_x_s[k];
				rt_r_s[k+1] <= rt_r_s[k] >> 1;
			end
			rt_scl_s[k+1]  <= rt_scl_s[k];
			rt_zero_s[k+1] <= rt_zero_s[k];
			rt_neg_s[k+1]  <= rt_neg_s[k];
		end
	end

	// numerator setup: scaled component times one, plus half the norm
	logic [2:0][DVW-1:0] dv_rem_s  [0:QB];
	logic [2:0][QB-1:0]  dv_q_s    [0:QB];
	logic [RT_W-1:0]     dv_n_s    [0:QB];
	logic                dv_zero_s [0:QB];
	logic [2:0]          dv_neg_s  [0:QB];
	logic [RT_W-1:0]     root_n;

	assign root_n = rt_r_s[RT_W][RT_W-1:0];

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			dv_rem_s[0][c] <= DVW'((NUMW'(rt_scl_s[RT_W][c]) << FRAC_BITS)
				+ NUMW'(root_n >> 1));
			dv_q_s[0][c] <= '0;
		end
		dv_n_s[0]    <= root_n;
		dv_zero_s[0] <= rt_zero_s[RT_W];
		dv_neg_s[0]  <= rt_neg_s[RT_W];
	end

	// restoring divide, one quotient bit per stage, three lanes
	for (genvar j = 0; j < QB; j++) begin : g_div
		localparam int QI = QB - 1 - j;
		logic [DVW-1:0] dsor;

		assign dsor = DVW'(dv_n_s[j]) << QI;

		always_ff @(posedge clk) begin
			for (int c = 0; c < 3; c++) begin
				if (dv_rem_s[j][c] >= dsor) begin
					dv_rem_s[j+1][c] <= dv_rem_s[j][c] - dsor;
					dv_q_s[j+1][c]   <= dv_q_s[j][c] | (QB'(1) << QI);
				end else begin
					dv_rem_s[j+1][c] <= dv_rem_s[j][c];
					dv_q_s[j+1][c]   <= dv_q_s[j][c];
				end
			end
			dv_n_s[j+1]    <= dv_n_s[j];
			dv_zero_s[j+1] <= dv_zero_s[j];
			dv_neg_s[j+1]  <= dv_neg_s[j];
		end
	end

	// output: restore sign, force zero vector
	logic [OW-1:0] qx [3];

	always_comb begin
		for (int c = 0; c < 3; c++) qx[c] = OW'(dv_q_s[QB][c]);
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			if (dv_zero_s[QB]) begin
				out_vec[c] <= '0;
			end else if (dv_neg_s[QB][c]) begin
				out_vec[c] <= ~qx[c] + 1'b1;
			end else begin
				out_vec[c] <= qx[c];
			end
		end
	end

endmodule

// ===== rtl/look_at_view_matrix.sv =====
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Camera view basis rows and translation from eye, target and up in signed
// fixed point, through two normalize units (root and divide one bit per stage).
// Throughput: one beat per clock; busy never rises, done pulses once per beat.
// Reset clears the valid pipeline and handedness (right-handed).
// ----------------------------------------------------------------------------
module look_at_view_matrix import lav_pkg::*; #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	output logic                          done,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,
	input  logic signed [WORD_BITS-1:0]   eye_x,
	input  logic signed [WORD_BITS-1:0]   eye_y,
	input  logic signed [WORD_BITS-1:0]   eye_z,
	input  logic signed [WORD_BITS-1:0]   target_x,
	input  logic signed [WORD_BITS-1:0]   target_y,
	input  logic signed [WORD_BITS-1:0]   target_z,
	input  logic signed [WORD_BITS-1:0]   upward_x,
	input  logic signed [WORD_BITS-1:0]   upward_y,
	input  logic signed [WORD_BITS-1:0]   upward_z,
	output logic signed [FRAC_BITS+1:0]   row0_x,
	output logic signed [FRAC_BITS+1:0]   row0_y,
	output logic signed [FRAC_BITS+1:0]   row0_z,
	output logic signed [FRAC_BITS+1:0]   row1_x,
	output logic signed [FRAC_BITS+1:0]   row1_y,
	output logic signed [FRAC_BITS+1:0]   row1_z,
	output logic signed [FRAC_BITS+1:0]   row2_x,
	output logic signed [FRAC_BITS+1:0]   row2_y,
	output logic signed [FRAC_BITS+1:0]   row2_z,
	output logic signed [WORD_BITS-1:0]   trans_0,
	output logic signed [WORD_BITS-1:0]   trans_1,
	output logic signed [WORD_BITS-1:0]   trans_2
);

	localparam int W       = WORD_BITS;
	localparam int RW      = FRAC_BITS + 2;
	localparam int DW      = W + 1;
	localparam int PRW     = RW + W;
	localparam int CW      = PRW + 1;
	localparam int UPW     = 2 * RW;
	localparam int UDW     = UPW + 1;
	localparam int DPW     = RW + W;
	localparam int DSW     = DPW + 2;
	localparam int RMW     = DSW - FRAC_BITS;
	localparam int SBA     = 1 + 6 * W;
	localparam int SBB     = 1 + 3 * W + 3 * RW;
	localparam int NLAT    = norm_latency(FRAC_BITS);
	localparam int LATENCY = 10 + 2 * NLAT;

	localparam logic [UDW-1:0] U_HALF = UDW'(1) << (FRAC_BITS - 1);
	localparam logic [UDW-1:0] U_ONE  = UDW'(1) << FRAC_BITS;
	localparam logic [RMW-1:0] T_HALF = RMW'(1) << (FRAC_BITS - 1);
	localparam logic [RMW-1:0] T_HI   = (RMW'(1) << (W - 1)) - 1'b1;
	localparam logic [RMW-1:0] T_LOM  = RMW'(1) << (W - 1);
	localparam logic signed [W-1:0] W_HI = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] W_LO = {1'b1, {(W-1){1'b0}}};

	// never stalls: a beat is taken every cycle
	assign busy = 1'b0;

	// handedness register
	logic handedness_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handedness_q <= 1'b0;
		end else if (cfg_we) begin
			handedness_q <= cfg_wdata;
		end
	end

	// valid bits of the local stages
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic na_vld, nb_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= na_vld;
			vld_s3 <= vld_s2;
			vld_s4 <= nb_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			done   <= vld_s9;
		end
	end

	// stage 1: capture beat, form target minus eye
	logic signed [DW-1:0] d_s1 [3];
	logic [2:0][W-1:0]    eye_s1;
	logic [2:0][W-1:0]    up_s1;
	logic                 hand_s1;

	always_ff @(posedge clk) begin
		d_s1[0]  <= DW'(target_x) - DW'(eye_x);
		d_s1[1]  <= DW'(target_y) - DW'(eye_y);
		d_s1[2]  <= DW'(target_z) - DW'(eye_z);
		eye_s1   <= {eye_z, eye_y, eye_x};
		up_s1    <= {upward_z, upward_y, upward_x};
		hand_s1  <= handedness_q;
	end

	// forward vector
	logic [2:0][RW-1:0] fa_vec;
	logic [SBA-1:0]     na_side;
	logic               hand_a;
	logic [2:0][W-1:0]  eye_a;
	logic [2:0][W-1:0]  up_a;

	lav_norm #(
		.IN_W      (DW),
		.FRAC_BITS (FRAC_BITS),
		.SB_W      (SBA)
	) u_norm_fwd (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s1),
		.in_vec   ({d_s1[2], d_s1[1], d_s1[0]}),
		.in_side  ({hand_s1, eye_s1, up_s1}),
		.out_vld  (na_vld),
		.out_vec  (fa_vec),
		.out_side (na_side)
	);

	assign {hand_a, eye_a, up_a} = na_side;

	// stage 2: products of forward with up
	logic signed [PRW-1:0] pa_s2 [3];
	logic signed [PRW-1:0] pb_s2 [3];
	logic [2:0][RW-1:0]    f_s2;
	logic [2:0][W-1:0]     eye_s2;
	logic                  hand_s2;

	always_ff @(posedge clk) begin
		pa_s2[0] <= $signed(fa_vec[1]) * $signed(up_a[2]);
		pb_s2[0] <= $signed(fa_vec[2]) * $signed(up_a[1]);
		pa_s2[1] <= $signed(fa_vec[2]) * $signed(up_a[0]);
		pb_s2[1] <= $signed(fa_vec[0]) * $signed(up_a[2]);
		pa_s2[2] <= $signed(fa_vec[0]) * $signed(up_a[1]);
		pb_s2[2] <= $signed(fa_vec[1]) * $signed(up_a[0]);
		f_s2     <= fa_vec;
		eye_s2   <= eye_a;
		hand_s2  <= hand_a;
	end

	// stage 3: side direction before normalize, flipped when left-handed
	logic signed [CW-1:0] c_s3 [3];
	logic [2:0][RW-1:0]   f_s3;
	logic [2:0][W-1:0]    eye_s3;
	logic                 hand_s3;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			c_s3[c] <= hand_s2 ? (CW'(pb_s2[c]) - CW'(pa_s2[c]))
				: (CW'(pa_s2[c]) - CW'(pb_s2[c]));
		end
		f_s3    <= f_s2;
		eye_s3  <= eye_s2;
		hand_s3 <= hand_s2;
	end

	// side vector
	logic [2:0][RW-1:0] sb_vec;
	logic [SBB-1:0]     nb_side;
	logic               hand_b;
	logic [2:0][W-1:0]  eye_b;
	logic [2:0][RW-1:0] f_b;

	lav_norm #(
		.IN_W      (CW),
		.FRAC_BITS (FRAC_BITS),
		.SB_W      (SBB)
	) u_norm_side (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.in_vec   ({c_s3[2], c_s3[1], c_s3[0]}),
		.in_side  ({hand_s3, eye_s3, f_s3}),
		.out_vld  (nb_vld),
		.out_vec  (sb_vec),
		.out_side (nb_side)
	);

	assign {hand_b, eye_b, f_b} = nb_side;

	// stage 4: products for the up vector
	logic [2:0][RW-1:0]    xa;
	logic [2:0][RW-1:0]    xb;
	logic signed [UPW-1:0] ua_s4 [3];
	logic signed [UPW-1:0] ub_s4 [3];
	logic [2:0][RW-1:0]    s_s4, f_s4;
	logic [2:0][W-1:0]     eye_s4;
	logic                  hand_s4;

	assign xa = hand_b ? f_b : sb_vec;
	assign xb = hand_b ? sb_vec : f_b;

	always_ff @(posedge clk) begin
		ua_s4[0] <= $signed(xa[1]) * $signed(xb[2]);
		ub_s4[0] <= $signed(xa[2]) * $signed(xb[1]);
		ua_s4[1] <= $signed(xa[2]) * $signed(xb[0]);
		ub_s4[1] <= $signed(xa[0]) * $signed(xb[2]);
		ua_s4[2] <= $signed(xa[0]) * $signed(xb[1]);
		ub_s4[2] <= $signed(xa[1]) * $signed(xb[0]);
		s_s4     <= sb_vec;
		f_s4     <= f_b;
		eye_s4   <= eye_b;
		hand_s4  <= hand_b;
	end

	// stage 5: product differences
	logic signed [UDW-1:0] ud_s5 [3];
	logic [2:0][RW-1:0]    s_s5, f_s5;
	logic [2:0][W-1:0]     eye_s5;
	logic                  hand_s5;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) ud_s5[c] <= UDW'(ua_s4[c]) - UDW'(ub_s4[c]);
		s_s5    <= s_s4;
		f_s5    <= f_s4;
		eye_s5  <= eye_s4;
		hand_s5 <= hand_s4;
	end

	// stage 6: round half away from zero, clamp to one
	logic [UDW-1:0]     umag [3];
	logic [UDW-1:0]     urnd [3];
	logic [RW-1:0]      uclp [3];
	logic [2:0][RW-1:0] u_s6, s_s6, f_s6;
	logic [2:0][W-1:0]  eye_s6;
	logic               hand_s6;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			umag[c] = ud_s5[c][UDW-1] ? (~ud_s5[c] + 1'b1) : ud_s5[c];
			urnd[c] = (umag[c] + U_HALF) >> FRAC_BITS;
			uclp[c] = (urnd[c] > U_ONE) ? RW'(U_ONE) : RW'(urnd[c]);
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			u_s6[c] <= ud_s5[c][UDW-1] ? (~uclp[c] + 1'b1) : uclp[c];
		end
		s_s6    <= s_s5;
		f_s6    <= f_s5;
		eye_s6  <= eye_s5;
		hand_s6 <= hand_s5;
	end

	// stage 7: order rows, products with eye
	logic [2:0][2:0][RW-1:0] rows_c;
	logic [2:0][2:0][RW-1:0] rows_s7, rows_s8, rows_s9;
	logic signed [DPW-1:0]   dp_s7 [3][3];

	assign rows_c[0] = s_s6;
	assign rows_c[1] = hand_s6 ? u_s6 : f_s6;
	assign rows_c[2] = hand_s6 ? f_s6 : u_s6;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			for (int c = 0; c < 3; c++) begin
				dp_s7[k][c] <= $signed(rows_c[k][c]) * $signed(eye_s6[c]);
			end
		end
		rows_s7 <= rows_c;
	end

	// stage 8: dot sums
	logic signed [DSW-1:0] ds_s8 [3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			ds_s8[k] <= DSW'(dp_s7[k][0]) + DSW'(dp_s7[k][1]) + DSW'(dp_s7[k][2]);
		end
		rows_s8 <= rows_s7;
	end

	// stage 9: rounded magnitude of each dot
	logic [DSW-1:0] dmag [3];
	logic [RMW-1:0] tr_mag_s9 [3];
	logic [2:0]     tr_neg_s9;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dmag[k] = ds_s8[k][DSW-1] ? (~ds_s8[k] + 1'b1) : ds_s8[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			tr_mag_s9[k] <= RMW'((dmag[k] + DSW'(T_HALF)) >> FRAC_BITS);
			tr_neg_s9[k] <= ds_s8[k][DSW-1];
		end
		rows_s9 <= rows_s8;
	end

	// stage 10: negate and saturate, drive the result beat
	logic signed [W-1:0] tr_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (tr_neg_s9[k]) begin
				tr_c[k] = (tr_mag_s9[k] > T_HI) ? W_HI : W'(tr_mag_s9[k]);
			end else begin
				tr_c[k] = (tr_mag_s9[k] > T_LOM) ? W_LO : W'(~tr_mag_s9[k] + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		row0_x  <= rows_s9[0][0];
		row0_y  <= rows_s9[0][1];
		row0_z  <= rows_s9[0][2];
		row1_x  <= rows_s9[1][0];
		row1_y  <= rows_s9[1][1];
		row1_z  <= rows_s9[1][2];
		row2_x  <= rows_s9[2][0];
		row2_y  <= rows_s9[2][1];
		row2_z  <= rows_s9[2][2];
		trans_0 <= tr_c[0];
		trans_1 <= tr_c[1];
		trans_2 <= tr_c[2];
	end

endmodule

// ===== rtl/lav_checker.sv =====
// ----------------------------------------------------------------------------
// lav_checker
// Port-level checks on the view-matrix block: fixed latency, no stalls,
// unit-range basis rows.
// ----------------------------------------------------------------------------
`include "look_at_view_matrix_defines.svh"

module lav_checker #(
	parameter int FRAC_BITS = 16,
	parameter int LATENCY = 120
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic signed [FRAC_BITS+1:0] row0_x,
	input logic signed [FRAC_BITS+1:0] row0_y,
	input logic signed [FRAC_BITS+1:0] row0_z,
	input logic signed [FRAC_BITS+1:0] row1_x,
	input logic signed [FRAC_BITS+1:0] row1_y,
	input logic signed [FRAC_BITS+1:0] row1_z,
	input logic signed [FRAC_BITS+1:0] row2_x,
	input logic signed [FRAC_BITS+1:0] row2_y,
	input logic signed [FRAC_BITS+1:0] row2_z
);

	localparam logic signed [FRAC_BITS+1:0] ONE =
		$signed((FRAC_BITS+2)'(1) << FRAC_BITS);

	function automatic logic in_unit(input logic signed [FRAC_BITS+1:0] v);
		return (v <= ONE) && (v >= -ONE);
	endfunction

	// every basis component stays within plus or minus one
	logic rows_ok;

	assign rows_ok = in_unit(row0_x) && in_unit(row0_y) && in_unit(row0_z)
		&& in_unit(row1_x) && in_unit(row1_y) && in_unit(row1_z)
		&& in_unit(row2_x) && in_unit(row2_y) && in_unit(row2_z);

	`LAV_NEVER(a_busy_low, busy)
	`LAV_AFTER(a_beat_lands, start, done, LATENCY)
	`LAV_AFTER(a_no_spurious, !start, !done, LATENCY)
	`LAV_IMPLY(a_rows_unit, done, rows_ok)

endmodule

bind look_at_view_matrix lav_checker #(
	.FRAC_BITS (FRAC_BITS),
	.LATENCY   (LATENCY)
) u_lav_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.row0_x (row0_x),
	.row0_y (row0_y),
	.row0_z (row0_z),
	.row1_x (row1_x),
	.row1_y (row1_y),
	.row1_z (row1_z),
	.row2_x (row2_x),
	.row2_y (row2_y),
	.row2_z (row2_z)
);
